// ----- hw/rtl/prc_pkg.sv -----
`default_nettype none

package prc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CordicN = (CORDIC_STEPS < 8) ? 8 : ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS);

  localparam int CoordW = 32;
  localparam int DiffW = CoordW + 1;
  localparam int AngleW = 26;
  localparam int CordW = 32;

  localparam logic signed [CordW-1:0] ATAN_TAB [32] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877465,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115,
    32'sd57,        32'sd29,        32'sd14,        32'sd7,
    32'sd4,         32'sd2,         32'sd1,         32'sd0
  };

  localparam logic signed [CordW-1:0] GAIN_TAB [9] = '{
    32'sd652039507, 32'sd652034532, 32'sd652033289, 32'sd652032978,
    32'sd652032900, 32'sd652032881, 32'sd652032876, 32'sd652032874,
    32'sd652032874
  };

  localparam logic signed [CordW-1:0] GainInit =
    GAIN_TAB[((CordicN > 16) ? 16 : CordicN) - 8];

  typedef struct packed {
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic                     neg;
  } prc_side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/prc_cordic.sv -----
`default_nettype none

module prc_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [prc_pkg::CordW-1:0]    z_i,
  input  prc_pkg::prc_side_t                  side_i,
  output logic                                valid_o,
  output logic signed [prc_pkg::CordW-1:0]    x_o,
  output logic signed [prc_pkg::CordW-1:0]    y_o,
  output prc_pkg::prc_side_t                  side_o
);
  import prc_pkg::*;

  logic signed [CordW-1:0] x_q [CordicN];
  logic signed [CordW-1:0] y_q [CordicN];
  logic signed [CordW-1:0] z_q [CordicN];
  prc_side_t               side_q [CordicN];
  logic                    valid_q [CordicN];

  for (genvar k = 0; k < CordicN; k++) begin : g_stage
    logic signed [CordW-1:0] x_in, y_in, z_in, x_sh, y_sh;
    prc_side_t               side_in;
    logic                    v_in;

    if (k == 0) begin : g_first
      assign x_in    = GainInit;
      assign y_in    = '0;
      assign z_in    = z_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign y_in    = y_q[k-1];
      assign z_in    = z_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = valid_q[k-1];
    end

    assign x_sh = x_in >>> k;
    assign y_sh = y_in >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if (!z_in[CordW-1]) begin
          x_q[k] <= x_in - y_sh;
          y_q[k] <= y_in + x_sh;
          z_q[k] <= z_in - ATAN_TAB[k];
        end else begin
          x_q[k] <= x_in + y_sh;
          y_q[k] <= y_in - x_sh;
          z_q[k] <= z_in + ATAN_TAB[k];
        end
      end
    end
  end

  assign valid_o = valid_q[CordicN-1];
  assign x_o     = x_q[CordicN-1];
  assign y_o     = y_q[CordicN-1];
  assign side_o  = side_q[CordicN-1];

endmodule

`default_nettype wire

// ----- hw/rtl/point_rotate_about_center.sv -----
`default_nettype none

// Rotates a Q20.12 point about a Q20.12 center by an angle in 1/65536 degree
// (counter-clockwise positive, any value of the 26-bit field, reduced modulo
// 360 degrees). One item is taken per cycle while the pipeline advances. Each
// item passes through the offset and half-turn reduction register, the
// quarter-turn reduction register, one register per CORDIC micro-rotation
// stage, then cosine/sine sign fix, multiply, sum with rounding, and the
// center add with saturation into the output register. The whole pipeline
// advances whenever the output register is empty or being taken, so
// s_axis_tready follows m_axis_tready while the output holds an item.
// m_axis_tuser is the overflow flag: high when either coordinate saturated.

module point_rotate_about_center (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x [31:0], point_y [63:32], center_x [95:64], center_y [127:96],
  // angle [153:128], zero [159:154]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rotated_x [31:0], rotated_y [63:32]
  output logic [63:0]  m_axis_tdata,
  // overflow [0]
  output logic         m_axis_tuser
);
  import prc_pkg::*;

  localparam int A1W = AngleW + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int SumW = ProdW + 1;
  localparam int ShW = SumW - 30;
  localparam int ResW = ShW + 1;

  localparam logic signed [A1W-1:0] HalfTurn    = 27'sd11796480;
  localparam logic signed [A1W-1:0] FullTurn    = 27'sd23592960;
  localparam logic signed [A1W-1:0] QuarterTurn = 27'sd5898240;
  localparam logic signed [SumW-1:0] RoundHalf  = SumW'(64'sd536870912);
  localparam logic signed [ResW-1:0] SatMax     = ResW'(64'sd2147483647);
  localparam logic signed [ResW-1:0] SatMin     = ResW'(-64'sd2147483648);

  logic adv;

  // input unpack and half-turn reduction
  logic signed [CoordW-1:0] in_px, in_py, in_cx, in_cy;
  logic signed [AngleW-1:0] in_a;
  logic signed [A1W-1:0]    a0, a1_d;

  assign in_px = $signed(s_axis_tdata[31:0]);
  assign in_py = $signed(s_axis_tdata[63:32]);
  assign in_cx = $signed(s_axis_tdata[95:64]);
  assign in_cy = $signed(s_axis_tdata[127:96]);
  assign in_a  = $signed(s_axis_tdata[153:128]);
  assign a0    = A1W'(in_a);

  always_comb begin
    a1_d = a0;
    if (a0 >= HalfTurn) begin
      a1_d = a0 - FullTurn;
    end else if (a0 < -HalfTurn) begin
      a1_d = a0 + FullTurn;
    end
  end

  logic                     v1_q;
  logic signed [DiffW-1:0]  dx1_q, dy1_q;
  logic signed [CoordW-1:0] cx1_q, cy1_q;
  logic signed [A1W-1:0]    a1_q;

  // quarter-turn reduction
  logic signed [A1W-1:0]   a2;
  logic                    neg_d;
  logic signed [CordW-1:0] z_d;

  always_comb begin
    a2    = a1_q;
    neg_d = 1'b0;
    if (a1_q > QuarterTurn) begin
      a2    = a1_q - HalfTurn;
      neg_d = 1'b1;
    end else if (a1_q < -QuarterTurn) begin
      a2    = a1_q + HalfTurn;
      neg_d = 1'b1;
    end
  end

  assign z_d = $signed({a2[23:0], 8'd0});

  logic                    v2_q;
  logic signed [CordW-1:0] z2_q;
  prc_side_t               side2_q;

  logic                    vc;
  logic signed [CordW-1:0] xc, yc;
  prc_side_t               sidec;

  prc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .z_i     (z2_q),
    .side_i  (side2_q),
    .valid_o (vc),
    .x_o     (xc),
    .y_o     (yc),
    .side_o  (sidec)
  );

  logic                     v3_q;
  logic signed [DiffW-1:0]  c3_q, s3_q;
  prc_side_t                side3_q;

  logic                     v4_q;
  logic signed [ProdW-1:0]  pxc4_q, pys4_q, pxs4_q, pyc4_q;
  logic signed [CoordW-1:0] cx4_q, cy4_q;

  logic                     v5_q;
  logic signed [SumW-1:0]   sx5_q, sy5_q;
  logic signed [CoordW-1:0] cx5_q, cy5_q;

  // center add and saturation
  logic signed [ShW-1:0]    shx, shy;
  logic signed [ResW-1:0]   resx, resy;
  logic signed [CoordW-1:0] rx_d, ry_d;
  logic                     ovf_d;

  assign shx  = $signed(sx5_q[SumW-1:30]);
  assign shy  = $signed(sy5_q[SumW-1:30]);
  assign resx = ResW'(shx) + ResW'(cx5_q);
  assign resy = ResW'(shy) + ResW'(cy5_q);

  always_comb begin
    ovf_d = 1'b0;
    rx_d  = CoordW'(resx);
    ry_d  = CoordW'(resy);
    if (resx > SatMax) begin
      rx_d  = CoordW'(SatMax);
      ovf_d = 1'b1;
    end else if (resx < SatMin) begin
      rx_d  = CoordW'(SatMin);
      ovf_d = 1'b1;
    end
    if (resy > SatMax) begin
      ry_d  = CoordW'(SatMax);
      ovf_d = 1'b1;
    end else if (resy < SatMin) begin
      ry_d  = CoordW'(SatMin);
      ovf_d = 1'b1;
    end
  end

  logic                     out_v_q;
  logic signed [CoordW-1:0] rx_q, ry_q;
  logic                     ovf_q;

  // advance everything while the output slot is free or being taken
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= s_axis_tvalid;
      v2_q    <= v1_q;
      v3_q    <= vc;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      out_v_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q <= DiffW'(in_px) - DiffW'(in_cx);
      dy1_q <= DiffW'(in_py) - DiffW'(in_cy);
      cx1_q <= in_cx;
      cy1_q <= in_cy;
      a1_q  <= a1_d;

      z2_q        <= z_d;
      side2_q.dx  <= dx1_q;
      side2_q.dy  <= dy1_q;
      side2_q.cx  <= cx1_q;
      side2_q.cy  <= cy1_q;
      side2_q.neg <= neg_d;

      c3_q    <= sidec.neg ? -DiffW'(xc) : DiffW'(xc);
      s3_q    <= sidec.neg ? -DiffW'(yc) : DiffW'(yc);
      side3_q <= sidec;

      pxc4_q <= side3_q.dx * c3_q;
      pys4_q <= side3_q.dy * s3_q;
      pxs4_q <= side3_q.dx * s3_q;
      pyc4_q <= side3_q.dy * c3_q;
      cx4_q  <= side3_q.cx;
      cy4_q  <= side3_q.cy;

      sx5_q <= SumW'(pxc4_q) - SumW'(pys4_q) + RoundHalf;
      sy5_q <= SumW'(pxs4_q) + SumW'(pyc4_q) + RoundHalf;
      cx5_q <= cx4_q;
      cy5_q <= cy4_q;

      rx_q  <= rx_d;
      ry_q  <= ry_d;
      ovf_q <= ovf_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {ry_q, rx_q};
  assign m_axis_tuser  = ovf_q;

endmodule

`default_nettype wire

// ----- tb/point_rotate_about_center_tb.sv -----
`default_nettype none

module point_rotate_about_center_tb;

  localparam int  WatchdogLimit = 4000;
  localparam int  DrainCycles   = 40;
  localparam int  LongHoldLen   = 250;
  localparam int  LongHoldAt    = 1500;
  localparam int  RandPerPhase  = 650;
  localparam int  OneQ12        = 4096;
  localparam int  CoordMax      = 32'h7fffffff;
  localparam int  CoordMin      = 32'h80000000;
  localparam int  DegUnit       = 65536;
  localparam int  QuarterTurn   = 90 * DegUnit;
  localparam int  HalfTurn      = 180 * DegUnit;
  localparam int  FullTurn      = 360 * DegUnit;
  localparam int  AngleFieldMax = (1 << 25) - 1;
  localparam int  AngleFieldMin = -(1 << 25);
  localparam int  RotSteps      = (prc_pkg::CORDIC_STEPS < 8) ? 8 :
                                  ((prc_pkg::CORDIC_STEPS > 32) ? 32 : prc_pkg::CORDIC_STEPS);

  localparam longint ArcTanTab [32] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934,  30029717,  15018523,  7509720,
    3754917,   1877465,   938734,    469367,
    234684,    117342,    58671,     29335,
    14668,     7334,      3667,      1833,
    917,       458,       229,       115,
    57,        29,        14,        7,
    4,         2,         1,         0
  };

  localparam longint GainQ30 [9] = '{
    652039507, 652034532, 652033289, 652032978,
    652032900, 652032881, 652032876, 652032874,
    652032874
  };

  typedef struct packed {
    logic [5:0]         pad;
    logic signed [25:0] ang;
    logic signed [31:0] cy;
    logic signed [31:0] cx;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } pt_item_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] ry;
    logic [31:0] rx;
  } rot_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;

  pt_item_t    pending_pts [$];
  rot_result_t rot_expected [$];
  rot_result_t want;
  int          src_idle_pct = 6;
  int          snk_idle_pct = 81;
  int          n_rotated = 0;
  int          n_errors = 0;
  int          hold_cnt = 0;
  bit          long_hold_done = 1'b0;
  int          stuck_cycles = 0;

  point_rotate_about_center i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic rot_result_t rotate_point(pt_item_t it);
    longint              ang;
    longint              z;
    longint              xc;
    longint              yc;
    longint              xs;
    longint              ys;
    bit                  flip;
    logic signed [95:0]  dx;
    logic signed [95:0]  dy;
    logic signed [95:0]  cx;
    logic signed [95:0]  cy;
    logic signed [95:0]  c;
    logic signed [95:0]  s;
    logic signed [95:0]  sx;
    logic signed [95:0]  sy;
    rot_result_t         r;
    cx = longint'(it.cx);
    cy = longint'(it.cy);
    dx = longint'(it.px) - longint'(it.cx);
    dy = longint'(it.py) - longint'(it.cy);
    ang = longint'(it.ang);
    flip = 1'b0;
    if (ang >= HalfTurn) ang -= FullTurn;
    if (ang < -HalfTurn) ang += FullTurn;
    if (ang > QuarterTurn) begin
      ang -= HalfTurn;
      flip = 1'b1;
    end else if (ang < -QuarterTurn) begin
      ang += HalfTurn;
      flip = 1'b1;
    end
    z = ang * 256;
    xc = GainQ30[((RotSteps > 16) ? 16 : RotSteps) - 8];
    yc = 0;
    for (int i = 0; i < RotSteps; i++) begin
      xs = xc >>> i;
      ys = yc >>> i;
      if (z >= 0) begin
        xc = xc - ys;
        yc = yc + xs;
        z  = z - ArcTanTab[i];
      end else begin
        xc = xc + ys;
        yc = yc - xs;
        z  = z + ArcTanTab[i];
      end
    end
    c = flip ? -xc : xc;
    s = flip ? -yc : yc;
    sx = ((dx * c - dy * s + (96'sd1 <<< 29)) >>> 30) + cx;
    sy = ((dx * s + dy * c + (96'sd1 <<< 29)) >>> 30) + cy;
    r.ovf = 1'b0;
    if (sx > 96'sd2147483647) begin
      sx = 96'sd2147483647;
      r.ovf = 1'b1;
    end else if (sx < -96'sd2147483648) begin
      sx = -96'sd2147483648;
      r.ovf = 1'b1;
    end
    if (sy > 96'sd2147483647) begin
      sy = 96'sd2147483647;
      r.ovf = 1'b1;
    end else if (sy < -96'sd2147483648) begin
      sy = -96'sd2147483648;
      r.ovf = 1'b1;
    end
    r.rx = sx[31:0];
    r.ry = sy[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(int scale);
    logic [31:0] r;
    r = $urandom;
    case (scale)
      0, 1, 2, 3, 4: return {{12{r[19]}}, r[19:0]};
      5, 6:          return {{4{r[27]}}, r[27:0]};
      8: begin
        case ($urandom_range(4, 0))
          0:       return CoordMax;
          1:       return CoordMin;
          2:       return 32'd0;
          3:       return 32'hffffffff;
          default: return {1'b0, 31'(r[3:0])};
        endcase
      end
      default:     return r;
    endcase
  endfunction

  task automatic push_pt(int px, int py, int cx, int cy, int ang);
    pt_item_t it;
    it.pad = '0;
    it.px  = px;
    it.py  = py;
    it.cx  = cx;
    it.cy  = cy;
    it.ang = 26'(ang);
    pending_pts.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pts.size() != 0 || s_axis_tvalid || rot_expected.size() != 0);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rot_expected.push_back(rotate_point(pt_item_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pts.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_pts.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt      <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && n_rotated >= LongHoldAt) begin
        long_hold_done <= 1'b1;
        hold_cnt       <= LongHoldLen;
        m_axis_tready  <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_rotated++;
      if (rot_expected.size() == 0) begin
        $display("%0t: unexpected item x=%h y=%h ovf=%b", $time,
                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
        n_errors++;
      end else begin
        want = rot_expected.pop_front();
        if (m_axis_tdata[31:0] !== want.rx) begin
          $display("%0t: rotated_x expected %h, got %h", $time, want.rx, m_axis_tdata[31:0]);
          n_errors++;
        end
        if (m_axis_tdata[63:32] !== want.ry) begin
          $display("%0t: rotated_y expected %h, got %h", $time, want.ry, m_axis_tdata[63:32]);
          n_errors++;
        end
        if (m_axis_tuser !== want.ovf) begin
          $display("%0t: overflow expected %b, got %b", $time, want.ovf, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int scale;
    int ang;
    pt_item_t it;

    push_pt(0, 0, 0, 0, 0);
    push_pt(OneQ12, 0, 0, 0, QuarterTurn);
    push_pt(OneQ12, 0, 0, 0, -QuarterTurn);
    push_pt(OneQ12, 2 * OneQ12, -OneQ12, OneQ12, HalfTurn);
    push_pt(OneQ12, 0, 0, 0, -HalfTurn);
    push_pt(OneQ12, OneQ12, 0, 0, FullTurn);
    push_pt(OneQ12, OneQ12, 0, 0, -FullTurn);
    push_pt(3 * OneQ12, -OneQ12, OneQ12, OneQ12, AngleFieldMax);
    push_pt(3 * OneQ12, -OneQ12, OneQ12, OneQ12, AngleFieldMin);
    push_pt(5 * OneQ12, 7 * OneQ12, 0, 0, QuarterTurn + 1);
    push_pt(5 * OneQ12, 7 * OneQ12, 0, 0, QuarterTurn - 1);
    push_pt(5 * OneQ12, 7 * OneQ12, 0, 0, -QuarterTurn - 1);
    push_pt(5 * OneQ12, 7 * OneQ12, 0, 0, HalfTurn - 1);
    push_pt(5 * OneQ12, 7 * OneQ12, 0, 0, -HalfTurn + 1);
    push_pt(CoordMax, 0, CoordMin, 0, 0);
    push_pt(CoordMax, 0, CoordMin, 0, HalfTurn);
    push_pt(CoordMin, 0, CoordMax, 0, HalfTurn);
    push_pt(CoordMax, CoordMax, 0, 0, 45 * DegUnit);
    push_pt(CoordMin, CoordMin, 0, 0, 45 * DegUnit);
    push_pt(CoordMin, CoordMax, CoordMax, CoordMin, QuarterTurn);
    push_pt(-1, -1, 1, 1, 30 * DegUnit);
    push_pt(12345, -6789, 12345, -6789, 1234567);

    for (int p = 0; p < 3; p++) begin
      if (p > 0) begin
        wait_drained();
        src_idle_pct = (p == 1) ? 81 : 0;
        snk_idle_pct = (p == 1) ? 6 : 0;
      end
      for (int n = 0; n < RandPerPhase; n++) begin
        scale = $urandom_range(9, 0);
        it.pad = '0;
        it.px  = rand_coord(scale);
        it.py  = rand_coord(scale);
        if (scale == 9) begin
          it.cx = it.px;
          it.cy = it.py;
        end else begin
          it.cx = rand_coord(scale);
          it.cy = rand_coord(scale);
        end
        case ($urandom_range(7, 0))
          5:       ang = int'($urandom);
          6: begin
            case ($urandom_range(5, 0))
              0:       ang = QuarterTurn;
              1:       ang = -QuarterTurn;
              2:       ang = HalfTurn;
              3:       ang = -HalfTurn;
              4:       ang = FullTurn;
              default: ang = -FullTurn;
            endcase
            ang = ang + int'($urandom_range(4, 0)) - 2;
          end
          7:       ang = (int'($urandom_range(10, 0)) - 5) * QuarterTurn;
          default: ang = int'($urandom_range(2 * HalfTurn - 1, 0)) - HalfTurn;
        endcase
        it.ang = 26'(ang);
        pending_pts.push_back(it);
      end
      if (p == 0) begin
        repeat (3) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && rot_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/prc_pkg.sv
hw/rtl/prc_cordic.sv
hw/rtl/point_rotate_about_center.sv
tb/point_rotate_about_center_tb.sv
